// ----- src/lrf_pkg.sv -----
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared constants for the least-rotation finder: default string capacity
// and the fixed field widths of the stream words.
// ----------------------------------------------------------------------------
package lrf_pkg;

  // default capacity of the string store, in bytes
  localparam int MAX_LEN_DEF = 64;

  // field widths of the stream words
  localparam int BYTE_W = 8;
  localparam int OFS_W  = 6;

  // output tdata: byte and offset, padded to whole bytes
  localparam int OUT_DATA_W = ((BYTE_W + OFS_W + 7) / 8) * 8;

endpackage

// ----- src/least_rotation_finder.sv -----
// Sequence: bytes load at one per cycle; after the last byte a clear sweep of
//   the failure table, then the scan with its failure-link steps, then the
//   rotation is streamed, each byte held until its output word is taken.
// Throughput: one string at a time; in_tready stays low from the last byte
//   until the final output word is taken.
// Reset: rst_n (synchronous, active low) clears sequencer, length, overflow, valid.
// ----------------------------------------------------------------------------
// least_rotation_finder
// Collects a byte string, finds the start of its lexicographically least
// rotation with Booth's failure-function scan, then streams that rotation.
// ----------------------------------------------------------------------------
module least_rotation_finder #(
  parameter int MAX_LEN = lrf_pkg::MAX_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lrf_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] in_byte
  input  logic                          in_tlast,   // in_last
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lrf_pkg::OUT_DATA_W-1:0] out_tdata, // [7:0] out_byte, [13:8] rot_offset
  output logic                          out_tlast,  // out_last
  output logic                          out_tuser   // overflow
);

  import lrf_pkg::*;

  // widths derived from the capacity
  localparam int TW   = $clog2(MAX_LEN);         // text store address
  localparam int FAW  = $clog2(2 * MAX_LEN);     // failure table address
  localparam int FVW  = FAW + 1;                 // failure value, -1 or index
  localparam int JW   = $clog2(2 * MAX_LEN + 1); // scan position, up to 2n
  localparam int LW   = $clog2(MAX_LEN + 1);     // string length

  localparam logic [FVW-1:0] FAIL_NONE = '1;

  typedef enum logic [9:0] {
    S_LOAD  = 10'b0000000001,
    S_CLEAR = 10'b0000000010,
    S_FETCH = 10'b0000000100,
    S_FIRST = 10'b0000001000,
    S_CMP   = 10'b0000010000,
    S_CHAIN = 10'b0000100000,
    S_FIN   = 10'b0001000000,
    S_ERD   = 10'b0010000000,
    S_EWAIT = 10'b0100000000,
    S_EHOLD = 10'b1000000000
  } state_t;

  // memories
  logic [BYTE_W-1:0] text_mem [MAX_LEN];
  logic [FVW-1:0]    fail_mem [2 * MAX_LEN];

  state_t state_r, state_nxt;
  logic [LW-1:0]     len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [JW-1:0]     k_r, k_nxt;
  logic [FVW-1:0]    i_r, i_nxt;
  logic [BYTE_W-1:0] c_r, c_nxt;
  logic [TW-1:0]     best_r, best_nxt;
  logic [LW-1:0]     r_r, r_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [OFS_W-1:0]  out_ofs_r, out_ofs_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_ovf_r, out_ovf_nxt;

  logic              tx_we;
  logic [TW-1:0]     tx_waddr, tx_raddr;
  logic [BYTE_W-1:0] tx_rdata;
  logic              fl_we;
  logic [FAW-1:0]    fl_waddr, fl_raddr;
  logic [FVW-1:0]    fl_wdata, fl_rdata;

  logic              in_acc, out_acc;
  logic [JW-1:0]     lim;
  logic [JW-1:0]     j_inc;
  logic [JW-1:0]     k_fin;
  logic [JW:0]       chain_idx;

  // index into the doubled string, folded back by one compare and subtract
  function automatic logic [TW-1:0] wrap_idx(input logic [JW:0] v, input logic [LW-1:0] n);
    logic [JW:0] nn;
    nn = (JW + 1)'(n);
    return (v >= nn) ? TW'(v - nn) : TW'(v);
  endfunction

  assign in_acc    = in_tvalid && (state_r == S_LOAD);
  assign out_acc   = out_valid_r && out_tready;
  assign in_tready = (state_r == S_LOAD);
  assign lim       = JW'({len_r, 1'b0});
  assign j_inc     = j_r + JW'(1);

  // text position of the next chain compare, from the fresh failure value
  assign chain_idx = (JW + 1)'(k_r) + (JW + 1)'(fl_rdata[FAW-1:0]) + (JW + 1)'(1);

  // final start offset once the scan reaches 2n (k may jump to j there)
  assign k_fin = (state_r == S_FIN && !(c_r == tx_rdata) && c_r < tx_rdata) ? j_r : k_r;

  // text store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tx_we) begin
      text_mem[tx_waddr] <= in_tdata;
    end
    tx_rdata <= text_mem[tx_raddr];
  end

  // failure table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (fl_we) begin
      fail_mem[fl_waddr] <= fl_wdata;
    end
    fl_rdata <= fail_mem[fl_raddr];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    i_nxt         = i_r;
    c_nxt         = c_r;
    best_nxt      = best_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_ofs_nxt   = out_ofs_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    tx_we         = 1'b0;
    tx_waddr      = len_r[TW-1:0];
    tx_raddr      = '0;
    fl_we         = 1'b0;
    fl_waddr      = '0;
    fl_wdata      = FAIL_NONE;
    fl_raddr      = '0;

    unique case (state_r)
      // store bytes; drop and flag once full
      S_LOAD: begin
        if (in_acc) begin
          if (len_r < LW'(MAX_LEN)) begin
            tx_we   = 1'b1;
            len_nxt = len_r + LW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            j_nxt     = '0;
            state_nxt = S_CLEAR;
          end
        end
      end
      // set failure entries 0..2n-1 to none
      S_CLEAR: begin
        fl_we    = 1'b1;
        fl_waddr = FAW'(j_r);
        fl_wdata = FAIL_NONE;
        j_nxt    = j_inc;
        if (j_inc == lim) begin
          j_nxt     = JW'(1);
          k_nxt     = '0;
          state_nxt = S_FETCH;
        end
      end
      // read text[j] and the failure link at j-k-1
      S_FETCH: begin
        tx_raddr  = wrap_idx((JW + 1)'(j_r), len_r);
        fl_raddr  = FAW'(j_r - k_r - JW'(1));
        state_nxt = S_FIRST;
      end
      // take the link; end the chain or read the next compare byte
      S_FIRST, S_CHAIN: begin
        if (state_r == S_FIRST) begin
          c_nxt = tx_rdata;
        end
        i_nxt = fl_rdata;
        if (fl_rdata == FAIL_NONE) begin
          tx_raddr  = wrap_idx((JW + 1)'(k_r), len_r);
          state_nxt = S_FIN;
        end else begin
          tx_raddr  = wrap_idx(chain_idx, len_r);
          state_nxt = S_CMP;
        end
      end
      // compare c with text[k+i+1]; on a match record i+1, else follow link
      S_CMP: begin
        if (c_r == tx_rdata) begin
          fl_we    = 1'b1;
          fl_waddr = FAW'(j_r - k_r);
          fl_wdata = i_r + FVW'(1);
          j_nxt    = j_inc;
          if (j_inc == lim) begin
            best_nxt  = wrap_idx((JW + 1)'(k_r), len_r);
            r_nxt     = '0;
            state_nxt = S_ERD;
          end else begin
            state_nxt = S_FETCH;
          end
        end else begin
          if (c_r < tx_rdata) begin
            k_nxt = j_r - JW'(i_r[FAW-1:0]) - JW'(1);
          end
          fl_raddr  = i_r[FAW-1:0];
          state_nxt = S_CHAIN;
        end
      end
      // chain exhausted: compare c with text[k]
      S_FIN: begin
        fl_we = 1'b1;
        if (c_r == tx_rdata) begin
          fl_waddr = FAW'(j_r - k_r);
          fl_wdata = '0;
        end else if (c_r < tx_rdata) begin
          k_nxt    = j_r;
          fl_waddr = '0;
          fl_wdata = FAIL_NONE;
        end else begin
          fl_waddr = FAW'(j_r - k_r);
          fl_wdata = FAIL_NONE;
        end
        j_nxt = j_inc;
        if (j_inc == lim) begin
          best_nxt  = wrap_idx((JW + 1)'(k_fin), len_r);
          r_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      // emission: read the first byte of the rotation
      S_ERD: begin
        tx_raddr  = wrap_idx((JW + 1)'(best_r), len_r);
        state_nxt = S_EWAIT;
      end
      // load the output word
      S_EWAIT: begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = tx_rdata;
        out_ofs_nxt   = OFS_W'(best_r);
        out_last_nxt  = (r_r + LW'(1) == len_r);
        out_ovf_nxt   = ovf_r;
        state_nxt     = S_EHOLD;
      end
      // hold until taken, then fetch the next byte or finish
      S_EHOLD: begin
        tx_raddr = wrap_idx((JW + 1)'(best_r) + (JW + 1)'(r_r) + (JW + 1)'(1), len_r);
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            r_nxt     = r_r + LW'(1);
            state_nxt = S_EWAIT;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    i_r        <= i_nxt;
    c_r        <= c_nxt;
    best_r     <= best_nxt;
    r_r        <= r_nxt;
    out_byte_r <= out_byte_nxt;
    out_ofs_r  <= out_ofs_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_ofs_r, out_byte_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule
